@@ rtl/qau_pkg.sv @@
package qau_pkg;

    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [2:0] {
        K_ADD   = 3'd0,
        K_SUB   = 3'd1,
        K_MUL   = 3'd2,
        K_DIV   = 3'd3,
        K_CONJ  = 3'd4,
        K_SCALE = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef struct packed {
        logic       valid;
        logic       is_div;
        logic       div_zero;
        logic [3:0] neg;
        logic [3:0] dovf;
    } t_ctl;

endpackage

@@ rtl/qau_front.sv @@
module qau_front #(
    parameter int CW = 32,
    parameter int FB = 16,
    localparam int VW = 2 * CW + 3,
    localparam int RW = 2 * CW + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_valid,
    input  logic [2:0]             i_kind,
    input  logic [3:0][CW-1:0]     i_a,
    input  logic [3:0][CW-1:0]     i_b,
    output qau_pkg::t_ctl          o_ctl,
    output logic [3:0][VW-1:0]     o_v,
    output logic [3:0][RW-1:0]     o_r,
    output logic [3:0][CW-1:0]     o_x,
    output logic [RW-1:0]          o_d
);
    import qau_pkg::*;

    localparam int PW = 2 * CW + 1;
    localparam int NW = VW + FB;

    logic               r0_valid;
    t_kind              r0_kind;
    logic signed [CW-1:0] r0_a [4];
    logic signed [CW-1:0] r0_b [4];

    logic signed [CW:0]   bs [4];
    logic signed [PW-1:0] n_p [4][4];
    logic signed [PW-1:0] n_sq [4];

    logic               r1_valid;
    t_kind              r1_kind;
    logic signed [CW-1:0] r1_a [4];
    logic signed [CW-1:0] r1_b [4];
    logic signed [PW-1:0] r1_p [4][4];
    logic signed [PW-1:0] r1_sq [4];

    logic signed [VW-1:0] ham [4];
    logic signed [VW-1:0] n_v2 [4];
    logic [RW-1:0]        n_d2;

    logic               r2_valid;
    t_kind              r2_kind;
    logic signed [VW-1:0] r2_v [4];
    logic [RW-1:0]        r2_d;

    logic [VW-1:0] mag [4];
    logic [VW-1:0] shr [4];
    logic [NW-1:0] num [4];
    logic [NW-1:0] hi  [4];
    logic          is_div3;
    logic          is_trunc3;
    t_ctl          n_ctl3;
    logic [3:0][VW-1:0] n_v3;
    logic [3:0][RW-1:0] n_r3;
    logic [3:0][CW-1:0] n_x3;

    t_ctl               r3_ctl;
    logic [3:0][VW-1:0] r3_v;
    logic [3:0][RW-1:0] r3_r;
    logic [3:0][CW-1:0] r3_x;
    logic [RW-1:0]      r3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_adv) begin
            r0_valid <= i_valid;
        end
        if (i_adv) begin
            r0_kind <= t_kind'(i_kind);
            for (int c = 0; c < 4; c++) begin
                r0_a[c] <= i_a[c];
                r0_b[c] <= i_b[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (c != 0 && r0_kind == K_DIV) begin
                bs[c] = -(CW + 1)'(r0_b[c]);
            end else begin
                bs[c] = (CW + 1)'(r0_b[c]);
            end
        end
        for (int x = 0; x < 4; x++) begin
            for (int y = 0; y < 4; y++) begin
                n_p[x][y] = PW'(r0_a[x]) * PW'(bs[y]);
            end
            n_sq[x] = PW'(r0_b[x]) * PW'(r0_b[x]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= r0_valid;
        end
        if (i_adv) begin
            r1_kind <= r0_kind;
            for (int x = 0; x < 4; x++) begin
                r1_a[x]  <= r0_a[x];
                r1_b[x]  <= r0_b[x];
                r1_sq[x] <= n_sq[x];
                for (int y = 0; y < 4; y++) begin
                    r1_p[x][y] <= n_p[x][y];
                end
            end
        end
    end

    always_comb begin
        ham[0] = VW'(r1_p[0][0]) - VW'(r1_p[1][1]) - VW'(r1_p[2][2]) - VW'(r1_p[3][3]);
        ham[1] = VW'(r1_p[0][1]) + VW'(r1_p[1][0]) + VW'(r1_p[2][3]) - VW'(r1_p[3][2]);
        ham[2] = VW'(r1_p[0][2]) - VW'(r1_p[1][3]) + VW'(r1_p[2][0]) + VW'(r1_p[3][1]);
        ham[3] = VW'(r1_p[0][3]) + VW'(r1_p[1][2]) - VW'(r1_p[2][1]) + VW'(r1_p[3][0]);
        for (int c = 0; c < 4; c++) begin
            case (r1_kind)
                K_ADD:       n_v2[c] = VW'(r1_a[c]) + VW'(r1_b[c]);
                K_SUB:       n_v2[c] = VW'(r1_a[c]) - VW'(r1_b[c]);
                K_MUL,
                K_DIV:       n_v2[c] = ham[c];
                K_CONJ:      n_v2[c] = (c == 0) ? VW'(r1_a[c]) : -VW'(r1_a[c]);
                K_SCALE:     n_v2[c] = VW'(r1_p[c][0]);
                default:     n_v2[c] = '0;
            endcase
        end
        n_d2 = RW'($unsigned(r1_sq[0])) + RW'($unsigned(r1_sq[1]))
             + RW'($unsigned(r1_sq[2])) + RW'($unsigned(r1_sq[3]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
        end
        if (i_adv) begin
            r2_kind <= r1_kind;
            r2_d    <= n_d2;
            for (int c = 0; c < 4; c++) begin
                r2_v[c] <= n_v2[c];
            end
        end
    end

    always_comb begin
        is_div3   = (r2_kind == K_DIV);
        is_trunc3 = (r2_kind == K_MUL) || (r2_kind == K_SCALE);
        n_ctl3.valid    = r2_valid;
        n_ctl3.is_div   = is_div3;
        n_ctl3.div_zero = is_div3 && (r2_d == '0);
        for (int c = 0; c < 4; c++) begin
            mag[c] = r2_v[c][VW-1] ? VW'(-r2_v[c]) : VW'(r2_v[c]);
            shr[c] = mag[c] >> FB;
            num[c] = {mag[c], {FB{1'b0}}};
            hi[c]  = num[c] >> CW;
            n_ctl3.neg[c]  = r2_v[c][VW-1];
            n_ctl3.dovf[c] = hi[c] >= NW'(r2_d);
            n_r3[c] = hi[c][RW-1:0];
            n_x3[c] = num[c][CW-1:0];
            if (is_trunc3) begin
                n_v3[c] = r2_v[c][VW-1] ? -shr[c] : shr[c];
            end else begin
                n_v3[c] = r2_v[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (i_adv) begin
            r3_ctl <= n_ctl3;
        end
        if (i_adv) begin
            r3_v <= n_v3;
            r3_r <= n_r3;
            r3_x <= n_x3;
            r3_d <= r2_d;
        end
    end

    assign o_ctl = r3_ctl;
    assign o_v   = r3_v;
    assign o_r   = r3_r;
    assign o_x   = r3_x;
    assign o_d   = r3_d;

endmodule

@@ rtl/qau_div_step.sv @@
module qau_div_step #(
    parameter int CW = 32,
    localparam int VW = 2 * CW + 3,
    localparam int RW = 2 * CW + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  qau_pkg::t_ctl          i_ctl,
    input  logic [3:0][VW-1:0]     i_v,
    input  logic [3:0][RW-1:0]     i_r,
    input  logic [3:0][CW-1:0]     i_x,
    input  logic [RW-1:0]          i_d,
    output qau_pkg::t_ctl          o_ctl,
    output logic [3:0][VW-1:0]     o_v,
    output logic [3:0][RW-1:0]     o_r,
    output logic [3:0][CW-1:0]     o_x,
    output logic [RW-1:0]          o_d
);
    import qau_pkg::*;

    logic [RW:0]        tr  [4];
    logic [RW:0]        sub [4];
    logic [3:0]         qb;
    logic [3:0][RW-1:0] n_r;
    logic [3:0][CW-1:0] n_x;

    t_ctl               r_ctl;
    logic [3:0][VW-1:0] r_v;
    logic [3:0][RW-1:0] r_r;
    logic [3:0][CW-1:0] r_x;
    logic [RW-1:0]      r_d;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            tr[c]  = {i_r[c], i_x[c][CW-1]};
            sub[c] = tr[c] - {1'b0, i_d};
            qb[c]  = tr[c] >= {1'b0, i_d};
            n_r[c] = qb[c] ? sub[c][RW-1:0] : tr[c][RW-1:0];
            n_x[c] = {i_x[c][CW-2:0], qb[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
        if (i_adv) begin
            r_v <= i_v;
            r_r <= n_r;
            r_x <= n_x;
            r_d <= i_d;
        end
    end

    assign o_ctl = r_ctl;
    assign o_v   = r_v;
    assign o_r   = r_r;
    assign o_x   = r_x;
    assign o_d   = r_d;

endmodule

@@ rtl/quaternion_arithmetic_unit.sv @@
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------
// input    | i_valid / o_stall  | i_kind, i_a_real..i_a_k, i_b_real..i_b_k
// output   | o_valid / i_stall  | o_res_real..o_res_k, o_status
//
// One transfer per cycle in and out while the output is not stalled;
// the pipeline holds the four front stages, one stage per quotient bit
// and the output register.
// Reset clears only the valid bits and the control fields that travel with them.
// A stall on the output freezes the whole pipeline while the output is full.
module quaternion_arithmetic_unit #(
    parameter int COMPONENT_WIDTH = qau_pkg::COMP_WIDTH_DEF,
    parameter int FRACTION_BITS   = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_kind,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_real,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_i,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_j,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_k,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_real,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_i,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_j,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_k,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [COMPONENT_WIDTH-1:0] o_res_real,
    output logic signed [COMPONENT_WIDTH-1:0] o_res_i,
    output logic signed [COMPONENT_WIDTH-1:0] o_res_j,
    output logic signed [COMPONENT_WIDTH-1:0] o_res_k,
    output logic [1:0]                        o_status
);
    import qau_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int VW = 2 * CW + 3;
    localparam int RW = 2 * CW + 2;

    logic adv;

    logic [3:0][CW-1:0] a_in;
    logic [3:0][CW-1:0] b_in;

    t_ctl               s_ctl [CW+1];
    logic [3:0][VW-1:0] s_v   [CW+1];
    logic [3:0][RW-1:0] s_r   [CW+1];
    logic [3:0][CW-1:0] s_x   [CW+1];
    logic [RW-1:0]      s_d   [CW+1];

    t_ctl               t_end;
    logic [CW:0]        half;
    logic [CW-1:0]      max_v;
    logic [CW-1:0]      min_v;
    logic [3:0]         sat;
    logic [3:0][CW-1:0] n_res;
    logic [VW-1:0]      vv;
    logic [CW-1:0]      q;
    logic [1:0]         n_status;

    logic               r_out_valid;
    logic [3:0][CW-1:0] r_res;
    logic [1:0]         r_status;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    assign a_in = {i_a_k, i_a_j, i_a_i, i_a_real};
    assign b_in = {i_b_k, i_b_j, i_b_i, i_b_real};

    qau_front #(
        .CW (CW),
        .FB (FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_a     (a_in),
        .i_b     (b_in),
        .o_ctl   (s_ctl[0]),
        .o_v     (s_v[0]),
        .o_r     (s_r[0]),
        .o_x     (s_x[0]),
        .o_d     (s_d[0])
    );

    for (genvar g = 0; g < CW; g++) begin : g_div
        qau_div_step #(
            .CW (CW)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (s_ctl[g]),
            .i_v     (s_v[g]),
            .i_r     (s_r[g]),
            .i_x     (s_x[g]),
            .i_d     (s_d[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_v     (s_v[g+1]),
            .o_r     (s_r[g+1]),
            .o_x     (s_x[g+1]),
            .o_d     (s_d[g+1])
        );
    end

    always_comb begin
        t_end = s_ctl[CW];
        half  = (CW + 1)'(1) << (CW - 1);
        max_v = {1'b0, {(CW - 1){1'b1}}};
        min_v = {1'b1, {(CW - 1){1'b0}}};
        vv    = '0;
        q     = '0;
        for (int c = 0; c < 4; c++) begin
            vv = s_v[CW][c];
            q  = s_x[CW][c];
            sat[c]   = 1'b0;
            n_res[c] = '0;
            if (t_end.div_zero) begin
                n_res[c] = '0;
            end else if (t_end.is_div) begin
                if (t_end.dovf[c]
                    || (t_end.neg[c] && ({1'b0, q} > half))
                    || (!t_end.neg[c] && ({1'b0, q} > (half - 1'b1)))) begin
                    sat[c]   = 1'b1;
                    n_res[c] = t_end.neg[c] ? min_v : max_v;
                end else begin
                    n_res[c] = t_end.neg[c] ? -q : q;
                end
            end else if ((&vv[VW-1:CW-1]) || !(|vv[VW-1:CW-1])) begin
                n_res[c] = vv[CW-1:0];
            end else begin
                sat[c]   = 1'b1;
                n_res[c] = vv[VW-1] ? min_v : max_v;
            end
        end
        if (t_end.div_zero) begin
            n_status = ST_DIVZ;
        end else if (|sat) begin
            n_status = ST_OVF;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= t_end.valid;
        end
        if (adv) begin
            r_res    <= n_res;
            r_status <= n_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_res_real = r_res[0];
    assign o_res_i    = r_res[1];
    assign o_res_j    = r_res[2];
    assign o_res_k    = r_res[3];
    assign o_status   = r_status;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_DIVZ || o_status == ST_OVF))
        else $error("reserved status code");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DIVZ) |->
            (o_res_real == '0 && o_res_i == '0 && o_res_j == '0 && o_res_k == '0))
        else $error("divide by zero with nonzero result");

endmodule

@@ tb/sv/quaternion_result_checker.sv @@
module quaternion_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_i,
    input  logic signed [31:0] i_a_j,
    input  logic signed [31:0] i_a_k,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_i,
    input  logic signed [31:0] i_b_j,
    input  logic signed [31:0] i_b_k,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_res_real,
    input  logic signed [31:0] i_res_i,
    input  logic signed [31:0] i_res_j,
    input  logic signed [31:0] i_res_k,
    input  logic [1:0]         i_status,
    output int                 o_fails,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import qau_pkg::*;

    localparam int FRAC = 16;

    typedef logic signed [129:0] t_wide;
    typedef logic signed [31:0] t_comp;

    typedef struct {
        t_comp   comp[4];
        t_status status;
    } t_quat_result;

    localparam t_wide MAXV = t_wide'(64'sh7fffffff);
    localparam t_wide MINV = -t_wide'(64'sh80000000);

    t_quat_result expected_results[$];
    int fails = 0;

    assign o_fails   = fails;
    assign o_pending = expected_results.size();

    function automatic t_wide wmul(t_comp x, t_comp y);
        return t_wide'(x) * t_wide'(y);
    endfunction

    function automatic t_wide wabs(t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_wide toward_zero(t_wide v);
        t_wide m;
        m = wabs(v) >> FRAC;
        return (v < 0) ? -m : m;
    endfunction

    function automatic void hamilton_product(input t_comp a[4], input t_comp b[4],
                                             output t_wide p[4]);
        p[0] = wmul(a[0], b[0]) - wmul(a[1], b[1]) - wmul(a[2], b[2]) - wmul(a[3], b[3]);
        p[1] = wmul(a[0], b[1]) + wmul(a[1], b[0]) + wmul(a[2], b[3]) - wmul(a[3], b[2]);
        p[2] = wmul(a[0], b[2]) - wmul(a[1], b[3]) + wmul(a[2], b[0]) + wmul(a[3], b[1]);
        p[3] = wmul(a[0], b[3]) + wmul(a[1], b[2]) - wmul(a[2], b[1]) + wmul(a[3], b[0]);
    endfunction

    // A * conj(B), with the sign of B's vector part folded into the products
    function automatic void hamilton_conj(input t_comp a[4], input t_comp b[4],
                                          output t_wide p[4]);
        p[0] = wmul(a[0], b[0]) + wmul(a[1], b[1]) + wmul(a[2], b[2]) + wmul(a[3], b[3]);
        p[1] = -wmul(a[0], b[1]) + wmul(a[1], b[0]) - wmul(a[2], b[3]) + wmul(a[3], b[2]);
        p[2] = -wmul(a[0], b[2]) + wmul(a[1], b[3]) + wmul(a[2], b[0]) - wmul(a[3], b[1]);
        p[3] = -wmul(a[0], b[3]) - wmul(a[1], b[2]) + wmul(a[2], b[1]) + wmul(a[3], b[0]);
    endfunction

    function automatic t_quat_result quaternion_op(logic [2:0] kind, t_comp a[4],
                                                   t_comp b[4]);
        t_quat_result r;
        t_wide v[4];
        t_wide d;
        t_wide q;
        logic ovf;
        ovf = 1'b0;
        for (int c = 0; c < 4; c++) v[c] = '0;
        case (kind)
            K_ADD: for (int c = 0; c < 4; c++) v[c] = t_wide'(a[c]) + t_wide'(b[c]);
            K_SUB: for (int c = 0; c < 4; c++) v[c] = t_wide'(a[c]) - t_wide'(b[c]);
            K_MUL: begin
                hamilton_product(a, b, v);
                for (int c = 0; c < 4; c++) v[c] = toward_zero(v[c]);
            end
            K_DIV: begin
                d = wmul(b[0], b[0]) + wmul(b[1], b[1]) + wmul(b[2], b[2]) + wmul(b[3], b[3]);
                if (d == 0) begin
                    for (int c = 0; c < 4; c++) r.comp[c] = '0;
                    r.status = ST_DIVZ;
                    return r;
                end
                hamilton_conj(a, b, v);
                for (int c = 0; c < 4; c++) begin
                    q = (wabs(v[c]) << FRAC) / d;
                    v[c] = (v[c] < 0) ? -q : q;
                end
            end
            K_CONJ: begin
                v[0] = t_wide'(a[0]);
                for (int c = 1; c < 4; c++) v[c] = -t_wide'(a[c]);
            end
            K_SCALE: for (int c = 0; c < 4; c++) v[c] = toward_zero(wmul(a[c], b[0]));
            default: ;
        endcase
        for (int c = 0; c < 4; c++) begin
            if (v[c] > MAXV) begin
                r.comp[c] = 32'sh7fffffff;
                ovf = 1'b1;
            end else if (v[c] < MINV) begin
                r.comp[c] = 32'sh80000000;
                ovf = 1'b1;
            end else begin
                r.comp[c] = t_comp'(v[c]);
            end
        end
        r.status = ovf ? ST_OVF : ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_comp a[4];
        t_comp b[4];
        t_quat_result e;
        t_comp got[4];
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            a = '{i_a_real, i_a_i, i_a_j, i_a_k};
            b = '{i_b_real, i_b_i, i_b_j, i_b_k};
            expected_results.push_back(quaternion_op(i_kind, a, b));
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", 32'd0, 32'd0);
            end else begin
                e = expected_results.pop_front();
                got = '{i_res_real, i_res_i, i_res_j, i_res_k};
                if (got[0] !== e.comp[0]) report_mismatch("res_real", got[0], e.comp[0]);
                if (got[1] !== e.comp[1]) report_mismatch("res_i", got[1], e.comp[1]);
                if (got[2] !== e.comp[2]) report_mismatch("res_j", got[2], e.comp[2]);
                if (got[3] !== e.comp[3]) report_mismatch("res_k", got[3], e.comp[3]);
                if (i_status !== e.status)
                    report_mismatch("status", 32'(i_status), 32'(e.status));
            end
        end
    end

endmodule

@@ tb/sv/tb_quaternion_arithmetic_unit.sv @@
module tb_quaternion_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import qau_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] CMAX = 32'sh7fffffff;
    localparam logic signed [31:0] CMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_kind;
    logic signed [31:0] i_a_real, i_a_i, i_a_j, i_a_k;
    logic signed [31:0] i_b_real, i_b_i, i_b_j, i_b_k;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_res_real, o_res_i, o_res_j, o_res_k;
    logic [1:0]         o_status;
    int                 fails;
    int                 pending;
    int                 cycles = 0;
    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;

    quaternion_arithmetic_unit uut (.*);

    quaternion_result_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_kind(i_kind),
        .i_a_real(i_a_real), .i_a_i(i_a_i), .i_a_j(i_a_j), .i_a_k(i_a_k),
        .i_b_real(i_b_real), .i_b_i(i_b_i), .i_b_j(i_b_j), .i_b_k(i_b_k),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_res_real(o_res_real), .i_res_i(o_res_i), .i_res_j(o_res_j),
        .i_res_k(o_res_k), .i_status(o_status),
        .o_fails(fails), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < rx_stall_pct);

    task automatic send_quat(logic [2:0] kind, logic signed [31:0] ar, logic signed [31:0] ai,
                             logic signed [31:0] aj, logic signed [31:0] ak,
                             logic signed [31:0] br, logic signed [31:0] bi,
                             logic signed [31:0] bj, logic signed [31:0] bk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_a_real <= ar;
        i_a_i    <= ai;
        i_a_j    <= aj;
        i_a_k    <= ak;
        i_b_real <= br;
        i_b_i    <= bi;
        i_b_j    <= bj;
        i_b_k    <= bk;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(7))
            0: return $urandom;
            1: return $signed(32'($urandom_range(4)) == 0 ? CMIN :
                              32'($urandom_range(1)) == 0 ? CMAX : 32'sd0);
            2: return $signed({{12{$urandom_range(1) == 1}}, 20'($urandom)});
            3: return $signed({{8{$urandom_range(1) == 1}}, 24'($urandom)});
            default: return $signed({{14{$urandom_range(1) == 1}}, 18'($urandom)});
        endcase
    endfunction

    task automatic send_random();
        logic [2:0] kind;
        logic signed [31:0] b0, b1, b2, b3;
        kind = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
        b0 = rand_comp();
        b1 = rand_comp();
        b2 = rand_comp();
        b3 = rand_comp();
        if (kind == K_DIV && $urandom_range(9) == 0) begin
            b0 = '0;
            b1 = '0;
            b2 = '0;
            b3 = '0;
        end
        send_quat(kind, rand_comp(), rand_comp(), rand_comp(), rand_comp(), b0, b1, b2, b3);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_stall  = 1'b0;
        i_kind   = '0;
        i_a_real = '0;
        i_a_i    = '0;
        i_a_j    = '0;
        i_a_k    = '0;
        i_b_real = '0;
        i_b_i    = '0;
        i_b_j    = '0;
        i_b_k    = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct  = 29;
        rx_stall_pct = 47;
        send_quat(K_ADD, ONE, -ONE, 32'sd5, 32'sd0, ONE, ONE, -32'sd7, 32'sd3);
        send_quat(K_ADD, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, -32'sd1, 32'sd1);
        send_quat(K_SUB, CMIN, CMAX, 32'sd0, ONE, CMAX, CMIN, CMIN, ONE);
        send_quat(K_SUB, 32'sd100, -32'sd100, 32'sd1, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
        send_quat(K_MUL, ONE, 2 * ONE, 3 * ONE, 4 * ONE, -ONE, ONE, -2 * ONE, 32'sh8000);
        send_quat(K_MUL, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX);
        send_quat(K_MUL, -32'sd1, 32'sd1, -32'sd3, 32'sd7, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
        send_quat(K_DIV, ONE, 2 * ONE, 3 * ONE, 4 * ONE, ONE, ONE, ONE, ONE);
        send_quat(K_DIV, ONE, ONE, ONE, ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_quat(K_DIV, CMAX, CMIN, CMAX, CMIN, 32'sd1, 32'sd0, 32'sd0, 32'sd0);
        send_quat(K_DIV, -ONE, 32'sd3, 32'sd0, CMIN, CMIN, CMAX, CMIN, CMAX);
        send_quat(K_DIV, ONE, -ONE, ONE, -ONE, 32'sd0, 32'sd0, -32'sd1, 32'sd0);
        send_quat(K_CONJ, CMIN, CMIN, CMAX, 32'sd0, ONE, ONE, ONE, ONE);
        send_quat(K_CONJ, -ONE, ONE, -32'sd1, CMIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_quat(K_SCALE, ONE, -ONE, CMAX, CMIN, 2 * ONE, 32'sd0, 32'sd0, 32'sd0);
        send_quat(K_SCALE, CMAX, CMIN, -32'sd5, 32'sd5, CMIN, CMAX, CMAX, CMAX);
        send_quat(K_SCALE, 3 * ONE, -32'sd1, 32'sd1, ONE, -32'sh8000, 32'sd0, 32'sd0, 32'sd0);
        send_quat(3'd6, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
        send_quat(3'd7, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);

        drain();
        for (int n = 0; n < 230; n++) send_random();
        tx_idle_pct  = 47;
        rx_stall_pct = 29;
        for (int n = 0; n < 230; n++) send_random();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        for (int n = 0; n < 240; n++) send_random();
        drain();
        repeat (100) @(negedge i_clk);

        if (fails == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
